// ===== hw/rtl/stt_pkg.sv =====
// Package for the source text tokenizer: word types, mode codes, keyword table.
// No dependencies.
`default_nettype none
package stt_pkg;
  localparam int unsigned MaxWordLen = 128;
  localparam int unsigned MaxLitLen = 128;
  localparam int unsigned LineBits = 20;
  localparam int unsigned ColBits = 16;
  localparam int unsigned NumKw = 51;
  localparam int unsigned KwChars = 10;

  localparam logic [1:0] KindPay = 2'd0;
  localparam logic [1:0] KindTok = 2'd1;
  localparam logic [1:0] KindErr = 2'd2;

  localparam logic [3:0] ModeIdle = 4'd0;
  localparam logic [3:0] ModeWord = 4'd1;
  localparam logic [3:0] ModeNum = 4'd2;
  localparam logic [3:0] ModeOp = 4'd3;
  localparam logic [3:0] ModeCmt = 4'd4;
  localparam logic [3:0] ModeStr = 4'd5;
  localparam logic [3:0] ModeStrEsc = 4'd6;
  localparam logic [3:0] ModeChr = 4'd7;
  localparam logic [3:0] ModeChrEsc = 4'd8;

  localparam logic [6:0] ClsEof = 7'd0;
  localparam logic [6:0] ClsInvalid = 7'd1;
  localparam logic [6:0] ClsIdent = 7'd2;
  localparam logic [6:0] ClsInt = 7'd3;
  localparam logic [6:0] ClsChar = 7'd4;
  localparam logic [6:0] ClsString = 7'd5;
  localparam logic [6:0] ClsKwBase = 7'd26;

  localparam logic [2:0] ErrNone = 3'd0;
  localparam logic [2:0] ErrWordLong = 3'd1;
  localparam logic [2:0] ErrLitLong = 3'd2;
  localparam logic [2:0] ErrUnterm = 3'd3;
  localparam logic [2:0] ErrEscape = 3'd4;
  localparam logic [2:0] ErrChrLen = 3'd5;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [6:0]          token_class;
    logic [7:0]          payload_byte;
    logic [63:0]         literal_value;
    logic                value_overflow;
    logic [LineBits-1:0] start_line;
    logic [ColBits-1:0]  start_column;
    logic [ColBits-1:0]  end_column;
    logic [2:0]          error_code;
    logic                last_of_run;
  } out_word_t;

  // Keyword text, zero padded, first character in the low byte.
  typedef logic [KwChars*8-1:0] kw_text_t;
  localparam kw_text_t KwText [NumKw] = '{
    "dna", "sa", "loob", "kaerb", "nitliub", "rahc", "ssalc", "geled", "od",
    "file", "esle", "dne", "mune", "tpecxe", "eslaf", "yllanif", "rof", "nuf",
    "teg", "fi", "ni", "tni", "ecafretni", "si", "wen", "ton", "lin", "ro",
    "edirrevo", "dekcap", "etavirp", "porp", "detcetorp", "cilbup", "esiar",
    "ecruoser", "nruter", "fles", "tes", "citats", "gnirts", "tcurts",
    "hctiws", "neht", "siht", "eurt", "rav", "htiw", "nehw", "elihw", "dleiy"
  };

  function automatic logic [3:0] kw_len(input kw_text_t t);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < KwChars; i++) begin
      if (t[i*8 +: 8] != 8'd0) n = 4'(i + 1);
    end
    return n;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/stt_out_fifo.sv =====
// Four-entry result buffer that takes up to two words per cycle and hands out one.
// Depends on stt_pkg.
`default_nettype none
module stt_out_fifo import stt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push0_i,
  input  wire logic      push1_i,
  input  wire out_word_t push0_data_i,
  input  wire out_word_t push1_data_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);
  // Room means two entries stay free after this cycle's writes and read, which is
  // enough for every word of the next byte.
  out_word_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic pop;

  assign pop = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_data_o = mem_q[rd_q];
  assign cnt_d = cnt_q + 3'(push0_i) + 3'(push1_i) - 3'(pop);
  assign room_o = cnt_d <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wr_q] <= push0_data_i;
    if (push1_i) mem_q[wr_q + 2'd1] <= push1_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_q + 2'(push0_i) + 2'(push1_i);
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_d <= 3'd4) else $error("result buffer overflow");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 3'd0) else $error("pop from empty buffer");
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i) else $error("second word written without first");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/source_text_tokenizer.sv =====
// Top level of the source text tokenizer: lexer state, per-byte update, result buffer.
// Depends on stt_pkg and stt_out_fifo.
// A taken byte is held in the input register and decoded from it; its results are
// written to the result buffer and leave it in order, the first before the second.
// Throughput: one byte per cycle while the buffer keeps two free entries; one result
// leaves per cycle while out_ready_i is high. Reset: asynchronous, lexer idle at
// line 1 column 1, tab width 8.
`default_nettype none
module source_text_tokenizer import stt_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [4:0] cfg_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o
);
  localparam logic [ColBits-1:0] ColMax = '1;
  localparam logic [LineBits-1:0] LineMax = '1;

  logic [4:0] tab_q;
  logic [3:0] mode_q, mode_d;
  logic [7:0] pend_q, pend_d;
  logic [LineBits-1:0] line_q, line_d, tline_q, tline_d;
  logic [ColBits-1:0] col_q, col_d, tcol_q, tcol_d;
  logic [7:0] len_q, len_d;
  logic [NumKw-1:0] kw_q, kw_d;
  logic [63:0] acc_q, acc_d;
  logic sat_q, sat_d, halt_q, halt_d;
  logic [7:0] chv_q, chv_d;

  // Input register stage.
  logic     iv_q;
  in_word_t id_q;

  logic room, go;
  logic n0, n1;
  logic push0, push1;
  out_word_t w0, w1;

  assign cfg_ready_o = 1'b1;
  assign go = iv_q;
  assign in_ready_o = room;
  assign push0 = go && n0;
  assign push1 = go && n1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tab_q <= 5'd8;
    else if (cfg_valid_i) tab_q <= cfg_data_i;
  end

  // Column helpers.
  function automatic logic [ColBits-1:0] cadd(input logic [ColBits-1:0] c,
                                               input logic [4:0] n);
    logic [ColBits:0] s;
    s = {1'b0, c} + (ColBits+1)'(n);
    return s > {1'b0, ColMax} ? ColMax : s[ColBits-1:0];
  endfunction

  logic [ColBits-1:0] col_inc, end_bef;
  logic [7:0] c;
  logic eoi, is_ws, is_dg, idle_path;
  logic [NumKw-1:0] kw_hit;
  logic [6:0] word_cls;
  logic [63:0] acc_x10, acc_new;
  logic [67:0] acc_prod;
  logic [64:0] acc_sum;
  logic [3:0] dig;
  logic acc_ovf;
  logic [7:0] esc;
  logic esc_ok;
  logic [6:0] opc;

  always_comb begin
    c = id_q.char_byte;
    eoi = id_q.end_of_input;
    col_inc = cadd(col_q, 5'd1);
    end_bef = (col_q == ColMax) ? ColMax : (col_q > 1 ? col_q - 1'b1 : ColBits'(1));
    is_ws = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    is_dg = c >= "0" && c <= "9";
    dig = c[3:0];
    for (int k = 0; k < NumKw; k++) begin
      kw_hit[k] = (len_q < KwChars) && (KwText[k][(len_q[3:0])*8 +: 8] == c);
    end
    word_cls = ClsIdent;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (kw_q[k] && {4'd0, kw_len(KwText[k])} == len_q) word_cls = ClsKwBase + 7'(k);
    end
    // Times ten as two shifted copies; any carry past bit 63 means saturation.
    acc_prod = {3'b0, acc_q, 1'b0} + {1'b0, acc_q, 3'b0};
    acc_x10 = acc_prod[63:0];
    acc_sum = {1'b0, acc_x10} + 65'(dig);
    acc_new = acc_sum[63:0];
    acc_ovf = (acc_prod[67:64] != 4'd0) || acc_sum[64];
    unique case (c)
      "\\": begin esc = "\\"; esc_ok = 1'b1; end
      "'":  begin esc = "'";  esc_ok = 1'b1; end
      "\"": begin esc = "\""; esc_ok = 1'b1; end
      "n":  begin esc = 8'd10; esc_ok = 1'b1; end
      "t":  begin esc = 8'd9; esc_ok = 1'b1; end
      default: begin esc = 8'd0; esc_ok = 1'b0; end
    endcase
  end

  function automatic out_word_t mk(input logic [1:0] k, input logic [6:0] cl,
      input logic [7:0] p, input logic [63:0] v, input logic o,
      input logic [LineBits-1:0] l, input logic [ColBits-1:0] s,
      input logic [ColBits-1:0] e, input logic [2:0] er);
    out_word_t w;
    w.result_kind = k; w.token_class = cl; w.payload_byte = p;
    w.literal_value = v; w.value_overflow = o; w.start_line = l;
    w.start_column = s; w.end_column = e; w.error_code = er; w.last_of_run = 1'b0;
    return w;
  endfunction

  always_comb begin
    logic [6:0] cls1;
    logic [6:0] opd;
    logic [1:0] nres;
    logic isstr;
    logic tk_v;
    out_word_t tk;
    mode_d = mode_q; pend_d = pend_q; line_d = line_q; col_d = col_q;
    tline_d = tline_q; tcol_d = tcol_q; len_d = len_q; kw_d = kw_q;
    acc_d = acc_q; sat_d = sat_q; halt_d = halt_q; chv_d = chv_q;
    idle_path = 1'b0; nres = 2'd0; w0 = '0; w1 = '0;
    cls1 = '0; opd = '0; isstr = 1'b0; tk = '0; opc = '0; tk_v = 1'b0;
    if (!halt_q) begin
      unique case (mode_q)
        ModeWord: begin
          if (!eoi && (is_ws || is_dg)) begin
            if (len_q >= MaxWordLen) begin
              w0 = mk(KindErr, ClsIdent, '0, '0, 1'b0, tline_q, tcol_q, col_q, ErrWordLong);
              nres = 2'd1; halt_d = 1'b1;
            end else begin
              kw_d = kw_q & kw_hit; len_d = len_q + 1'b1;
              w0 = mk(KindPay, ClsIdent, c, '0, 1'b0, tline_q, tcol_q, col_q, ErrNone);
              nres = 2'd1; col_d = col_inc;
            end
          end else begin
            w0 = mk(KindTok, word_cls, '0, '0, 1'b0, tline_q, tcol_q, end_bef, ErrNone);
            nres = 2'd1; idle_path = 1'b1;
          end
        end
        ModeNum: begin
          if (!eoi && is_dg) begin
            if (sat_q || acc_ovf) begin acc_d = '1; sat_d = 1'b1; end
            else acc_d = acc_new;
            col_d = col_inc;
          end else begin
            w0 = mk(KindTok, ClsInt, '0, acc_q, sat_q, tline_q, tcol_q, end_bef, ErrNone);
            nres = 2'd1; idle_path = 1'b1;
          end
        end
        ModeOp: begin
          if (!eoi && c == "=") begin
            priority case (pend_q)
              "=": opc = 7'd12;
              "!": opc = 7'd13;
              "+": opc = 7'd22;
              "<": opc = 7'd16;
              ">": opc = 7'd17;
              default: opc = 7'd0;
            endcase
          end
          if (opc != 0) begin
            w0 = mk(KindTok, opc, '0, '0, 1'b0, tline_q, tcol_q, col_q, ErrNone);
            nres = 2'd1; col_d = col_inc; mode_d = ModeIdle;
          end else if (!eoi && c == "-" && pend_q == "-") begin
            col_d = col_inc; mode_d = ModeCmt;
          end else begin
            priority case (pend_q)
              "=": opd = 7'd18;
              "+": opd = 7'd19;
              "<": opd = 7'd14;
              ">": opd = 7'd15;
              "-": opd = 7'd20;
              default: opd = ClsInvalid;
            endcase
            w0 = mk(KindTok, opd, '0, '0, 1'b0, tline_q, tcol_q, end_bef, ErrNone);
            nres = 2'd1; idle_path = 1'b1;
          end
        end
        ModeCmt: begin
          if (eoi || c == 8'd10) idle_path = 1'b1;
          else col_d = col_inc;
        end
        ModeStr, ModeChr: begin
          isstr = mode_q == ModeStr;
          cls1 = isstr ? ClsString : ClsChar;
          if (eoi) begin
            w0 = mk(KindErr, cls1, '0, '0, 1'b0, tline_q, tcol_q, col_q,
                    len_q >= MaxLitLen ? ErrLitLong : ErrUnterm);
            nres = 2'd1; halt_d = 1'b1;
          end else if (c == (isstr ? 8'd34 : 8'd39)) begin
            nres = 2'd1;
            if (isstr) begin
              w0 = mk(KindTok, ClsString, '0, '0, 1'b0, tline_q, tcol_q, col_q, ErrNone);
              col_d = col_inc; mode_d = ModeIdle;
            end else if (len_q != 8'd1) begin
              w0 = mk(KindErr, ClsChar, '0, '0, 1'b0, tline_q, tcol_q, col_q, ErrChrLen);
              halt_d = 1'b1;
            end else begin
              w0 = mk(KindTok, ClsChar, '0, 64'(chv_q), 1'b0, tline_q, tcol_q, col_q,
                      ErrNone);
              col_d = col_inc; mode_d = ModeIdle;
            end
          end else if (len_q >= MaxLitLen) begin
            w0 = mk(KindErr, cls1, '0, '0, 1'b0, tline_q, tcol_q, col_q, ErrLitLong);
            nres = 2'd1; halt_d = 1'b1;
          end else if (c == 8'd10) begin
            w0 = mk(KindErr, cls1, '0, '0, 1'b0, tline_q, tcol_q, col_q,
                    9'(len_q) + 9'd1 >= 9'(MaxLitLen) ? ErrLitLong : ErrUnterm);
            nres = 2'd1; halt_d = 1'b1;
          end else if (c == "\\") begin
            mode_d = isstr ? ModeStrEsc : ModeChrEsc; col_d = col_inc;
          end else begin
            if (isstr) begin
              w0 = mk(KindPay, ClsString, c, '0, 1'b0, tline_q, tcol_q, col_q, ErrNone);
              nres = 2'd1;
            end else if (len_q == 0) chv_d = c;
            len_d = len_q + 1'b1; col_d = col_inc;
          end
        end
        ModeStrEsc, ModeChrEsc: begin
          isstr = mode_q == ModeStrEsc;
          if (eoi || !esc_ok) begin
            w0 = mk(KindErr, isstr ? ClsString : ClsChar, '0, '0, 1'b0, tline_q, tcol_q,
                    col_q, ErrEscape);
            nres = 2'd1; halt_d = 1'b1;
          end else begin
            if (isstr) begin
              w0 = mk(KindPay, ClsString, esc, '0, 1'b0, tline_q, tcol_q, col_q, ErrNone);
              nres = 2'd1;
            end else if (len_q == 0) chv_d = esc;
            len_d = len_q + 1'b1; col_d = col_inc;
            mode_d = isstr ? ModeStr : ModeChr;
          end
        end
        default: idle_path = 1'b1;
      endcase

      if (idle_path) begin
        mode_d = ModeIdle;
        tk = '0;
        if (eoi) begin
          tk = mk(KindTok, ClsEof, '0, '0, 1'b0, line_q, col_q, col_q, ErrNone);
          tk_v = 1'b1;
        end else begin
          tline_d = line_q; tcol_d = col_q;
          if (c == " ") col_d = col_inc;
          else if (c == 8'd9) col_d = cadd(col_q, tab_q == 0 ? 5'd1 : tab_q);
          else if (c == 8'd10) begin
            line_d = (line_q == LineMax) ? LineMax : line_q + 1'b1;
            col_d = ColBits'(1);
          end else if (is_ws) begin
            for (int k = 0; k < NumKw; k++) kw_d[k] = KwText[k][7:0] == c;
            len_d = 8'd1; mode_d = ModeWord; col_d = col_inc;
            tk = mk(KindPay, ClsIdent, c, '0, 1'b0, line_q, col_q, col_q, ErrNone);
            tk_v = 1'b1;
          end else if (is_dg) begin
            acc_d = 64'(dig); sat_d = 1'b0; mode_d = ModeNum; col_d = col_inc;
          end else if (c == 8'd39 || c == 8'd34) begin
            len_d = '0; chv_d = '0; col_d = col_inc;
            mode_d = (c == 8'd34) ? ModeStr : ModeChr;
          end else if (c == "=" || c == "!" || c == "+" || c == "<" || c == ">" ||
                       c == "-") begin
            pend_d = c; mode_d = ModeOp; col_d = col_inc;
          end else begin
            unique case (c)
              ".": cls1 = 7'd6;  "/": cls1 = 7'd7;  "(": cls1 = 7'd8;
              ")": cls1 = 7'd9;  "[": cls1 = 7'd10; "]": cls1 = 7'd11;
              "*": cls1 = 7'd21; ",": cls1 = 7'd23; ":": cls1 = 7'd24;
              ";": cls1 = 7'd25; default: cls1 = ClsInvalid;
            endcase
            tk = mk(KindTok, cls1, '0, '0, 1'b0, line_q, col_q, col_q, ErrNone);
            tk_v = 1'b1; col_d = col_inc;
          end
        end
        if (tk_v) begin
          if (nres == 2'd0) begin w0 = tk; nres = 2'd1; end
          else begin w1 = tk; nres = 2'd2; end
        end
      end
    end
    n0 = nres != 2'd0;
    n1 = nres == 2'd2;
    if (n1) w1.last_of_run = 1'b1;
    else w0.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
      mode_q <= ModeIdle; pend_q <= '0; line_q <= LineBits'(1); col_q <= ColBits'(1);
      tline_q <= LineBits'(1); tcol_q <= ColBits'(1); len_q <= '0; kw_q <= '1;
      acc_q <= '0; sat_q <= 1'b0; chv_q <= '0; halt_q <= 1'b0;
    end else begin
      if (go) begin
        mode_q <= mode_d; pend_q <= pend_d; line_q <= line_d; col_q <= col_d;
        tline_q <= tline_d; tcol_q <= tcol_d; len_q <= len_d; kw_q <= kw_d;
        acc_q <= acc_d; sat_q <= sat_d; chv_q <= chv_d; halt_q <= halt_d;
      end
      iv_q <= in_valid_i && in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) id_q <= in_data_i;
  end

  stt_out_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push0_i      (push0),
    .push1_i      (push1),
    .push0_data_i (w0),
    .push1_data_i (w1),
    .room_o       (room),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt cleared without reset");
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && halt_q) |-> !n0) else $error("result produced while halted");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && n1) |-> n0) else $error("second result without first");
`endif
endmodule
`default_nettype wire
